// File: sv/prq_pkg.sv
package prq_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int NODE_CAPACITY_DEF = 16;
  localparam int COORD_BITS_DEF = 32;
  localparam int CNT_W = 7;
  localparam int IDX_W = 6;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] entry_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_y;
  } in_word_t;

  typedef struct packed {
    logic [5:0] hit_index;
    logic hit;
    logic last;
  } out_word_t;
endpackage

// File: sv/prq_store.sv
module prq_store import prq_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic clk,
  input  logic wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic signed [COORD_BITS-1:0] wr_x,
  input  logic signed [COORD_BITS-1:0] wr_y,
  input  logic [AW-1:0] rd_addr,
  output logic signed [COORD_BITS-1:0] rd_x,
  output logic signed [COORD_BITS-1:0] rd_y
);
  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_x, wr_y};
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_x = rd_r[2*COORD_BITS-1:COORD_BITS];
  assign rd_y = rd_r[COORD_BITS-1:0];
endmodule

// File: sv/packed_rtree_point_range_query.sv
// query: each scanned point, up to min(point_count, MAX_POINTS), is read through the
// single memory read port and passes the read pipeline, and then the query closes with
// its last result word; the next word is taken once the receiver has taken that last word
// pending hits wait while the receiver stalls; an inverted box goes straight to the close
// load and remove complete when the word is taken; one word is handled at a time
// synchronous active-low reset clears point_count and the removed marks
module packed_rtree_point_range_query import prq_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_word_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_word_t out_data,
  input  logic cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DRAIN = 4'b0100,
    S_LAST = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [MAX_POINTS-1:0] removed_r;
  logic signed [COORD_BITS-1:0] bx0_r, bx1_r, by0_r, by1_r;
  logic [CNT_W-1:0] scan_r;
  logic [CNT_W-1:0] limit;
  logic rd_v_r;
  logic [AW-1:0] rd_i_r;
  logic pend_v_r;
  logic [AW-1:0] pend_i_r;
  logic signed [COORD_BITS-1:0] rx, ry;
  logic ov_r;
  out_word_t od_r;

  logic signed [COORD_BITS-1:0] ix, iy, ibx0, ibx1, iby0, iby1;
  logic accept, idx_ok;
  logic match;
  logic emit_go;

  assign ix = in_data.point_x[COORD_BITS-1:0];
  assign iy = in_data.point_y[COORD_BITS-1:0];
  assign ibx0 = in_data.box_min_x[COORD_BITS-1:0];
  assign ibx1 = in_data.box_max_x[COORD_BITS-1:0];
  assign iby0 = in_data.box_min_y[COORD_BITS-1:0];
  assign iby1 = in_data.box_max_y[COORD_BITS-1:0];

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign accept = in_valid && in_ready;
  assign idx_ok = CNT_W'(in_data.entry_index) < CNT_W'(MAX_POINTS);
  assign limit = (count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_r;

  // scan stalls while a pending hit cannot move to output
  logic stall;
  logic ov_set;

  // a stalled read repeats its address so the data stays with rd_i_r
  prq_store #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_store (
    .clk(clk),
    .wr_en(accept && in_data.func == FUNC_LOAD && idx_ok),
    .wr_addr(in_data.entry_index[AW-1:0]),
    .wr_x(ix),
    .wr_y(iy),
    .rd_addr(stall ? rd_i_r : scan_r[AW-1:0]),
    .rd_x(rx),
    .rd_y(ry)
  );

  assign match = rd_v_r && !removed_r[rd_i_r] && rx >= bx0_r && rx <= bx1_r &&
                 ry >= by0_r && ry <= by1_r;
  // output slot free this cycle
  assign emit_go = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_data = od_r;

  assign stall = pend_v_r && match && !emit_go;
  assign ov_set = ((state_r == S_SCAN || state_r == S_DRAIN) && !stall && match && pend_v_r) ||
                  (state_r == S_LAST && emit_go);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_data.func == FUNC_QUERY) begin
          if (ibx0 > ibx1 || iby0 > iby1) state_nxt = S_LAST;
          else state_nxt = S_SCAN;
        end
      end
      S_SCAN: if (!stall && scan_r + 1'b1 >= limit) state_nxt = S_DRAIN;
      S_DRAIN: if (!stall && !rd_v_r) state_nxt = S_LAST;
      S_LAST: if (emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      removed_r <= '0;
      rd_v_r <= 1'b0;
      pend_v_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) count_r <= cfg_wdata;
      if (ov_set) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      state_r <= state_nxt;
      if (accept) begin
        if (in_data.func == FUNC_LOAD && idx_ok) removed_r[in_data.entry_index[AW-1:0]] <= 1'b0;
        if (in_data.func == FUNC_REMOVE && idx_ok && CNT_W'(in_data.entry_index) < limit)
          removed_r[in_data.entry_index[AW-1:0]] <= 1'b1;
        if (in_data.func == FUNC_QUERY) begin
          bx0_r <= ibx0; bx1_r <= ibx1; by0_r <= iby0; by1_r <= iby1;
          scan_r <= '0;
          pend_v_r <= 1'b0;
          rd_v_r <= 1'b0;
        end
      end
      if (state_r == S_SCAN && limit == '0) begin
        rd_v_r <= 1'b0;
      end else if ((state_r == S_SCAN || state_r == S_DRAIN) && !stall) begin
        rd_v_r <= (state_r == S_SCAN);
        rd_i_r <= scan_r[AW-1:0];
        if (state_r == S_SCAN) scan_r <= scan_r + 1'b1;
        if (match) begin
          if (pend_v_r) begin
            od_r <= '{hit_index: IDX_W'(pend_i_r), hit: 1'b1, last: 1'b0};
          end
          pend_v_r <= 1'b1;
          pend_i_r <= rd_i_r;
        end
      end
      if (state_r == S_LAST && emit_go) begin
        pend_v_r <= 1'b0;
        if (pend_v_r) od_r <= '{hit_index: IDX_W'(pend_i_r), hit: 1'b1, last: 1'b1};
        else od_r <= '{hit_index: '0, hit: 1'b0, last: 1'b1};
      end
    end
  end
endmodule

// File: tb/testbench.sv
module testbench;
  import prq_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  packed_rtree_point_range_query DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predicted index state
  logic signed [31:0] pt_x [MAX_POINTS_DEF];
  logic signed [31:0] pt_y [MAX_POINTS_DEF];
  bit pt_gone [MAX_POINTS_DEF];
  int unsigned held_count = 0;

  out_word_t hit_q [$];
  int errors = 0;
  int words_sent = 0;
  int hits_seen = 0;
  int send_idle = 0;
  int recv_stall = 0;

  task automatic predict_word(in_word_t w);
    int unsigned lim;
    int n;
    out_word_t r;
    lim = (held_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : held_count;
    n = 0;
    case (w.func)
      FUNC_LOAD: begin
        pt_x[w.entry_index] = w.point_x;
        pt_y[w.entry_index] = w.point_y;
        pt_gone[w.entry_index] = 1'b0;
      end
      FUNC_REMOVE: begin
        if (w.entry_index < lim) pt_gone[w.entry_index] = 1'b1;
      end
      FUNC_QUERY: begin
        if (w.box_min_x <= w.box_max_x && w.box_min_y <= w.box_max_y) begin
          for (int i = 0; i < lim; i++) begin
            if (!pt_gone[i] && pt_x[i] >= w.box_min_x && pt_x[i] <= w.box_max_x &&
                pt_y[i] >= w.box_min_y && pt_y[i] <= w.box_max_y) begin
              r.hit_index = i[5:0];
              r.hit = 1'b1;
              r.last = 1'b0;
              hit_q = {hit_q, r};
              n++;
            end
          end
        end
        if (n == 0) begin
          r = '0;
          r.last = 1'b1;
          hit_q = {hit_q, r};
        end else begin
          hit_q[$].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // sends one word; returns at the edge that accepted it
  task automatic send_word(in_word_t w);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    predict_word(w);
    words_sent++;
    @(posedge clk);
  endtask

  // results are sampled mid-cycle, where they equal what the next edge takes
  always @(negedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (hit_q.size() == 0) begin
        $error("unexpected word: hit_index %0d hit %0d last %0d",
               out_data.hit_index, out_data.hit, out_data.last);
        errors++;
      end else begin
        e = hit_q.pop_front();
        if (out_data.hit_index !== e.hit_index) begin
          $error("hit_index: expected %0d actual %0d", e.hit_index, out_data.hit_index);
          errors++;
        end
        if (out_data.hit !== e.hit) begin
          $error("hit: expected %0d actual %0d", e.hit, out_data.hit);
          errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_data.last);
          errors++;
        end
        if (e.hit) hits_seen++;
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall);

  task automatic drain();
    in_valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_count(int unsigned v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    held_count = v;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord();
    int v;
    if ($urandom_range(0, 19) == 0) return $urandom;
    v = ($urandom_range(0, 15) - 8) * 65536;
    if ($urandom_range(0, 1)) v += $urandom_range(0, 65535);
    return v;
  endfunction

  function automatic in_word_t make_load(int idx, logic signed [31:0] x, logic signed [31:0] y);
    in_word_t w;
    w = '0;
    w.func = FUNC_LOAD;
    w.entry_index = idx[5:0];
    w.point_x = x;
    w.point_y = y;
    return w;
  endfunction

  function automatic in_word_t make_query(logic signed [31:0] x0, logic signed [31:0] x1,
                                          logic signed [31:0] y0, logic signed [31:0] y1);
    in_word_t w;
    w = '0;
    w.func = FUNC_QUERY;
    w.box_min_x = x0;
    w.box_max_x = x1;
    w.box_min_y = y0;
    w.box_max_y = y1;
    return w;
  endfunction

  function automatic in_word_t make_remove(int idx);
    in_word_t w;
    w = '0;
    w.func = FUNC_REMOVE;
    w.entry_index = idx[5:0];
    return w;
  endfunction

  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;

  // every point is written before any query can read it
  task automatic test_fill();
    for (int i = 0; i < MAX_POINTS_DEF; i++) send_word(make_load(i, pick_coord(), pick_coord()));
  endtask

  task automatic test_directed();
    in_word_t w;
    set_count(0);
    send_word(make_query(CMIN, CMAX, CMIN, CMAX));
    send_word(make_remove(5));
    set_count(64);
    send_word(make_load(0, CMAX, CMIN));
    send_word(make_load(63, CMIN, CMAX));
    send_word(make_query(CMIN, CMAX, CMIN, CMAX));
    send_word(make_query(CMAX, CMAX, CMIN, CMIN));
    send_word(make_query(CMIN, CMIN, CMAX, CMAX));
    send_word(make_query(CMAX, CMIN, CMIN, CMAX));
    send_word(make_query(CMIN, CMAX, 32'sd5, 32'sd4));
    send_word(make_query(32'sd1, 32'sd1, 32'sd3, 32'sd3));
    send_word(make_remove(0));
    send_word(make_remove(63));
    send_word(make_query(CMIN, CMAX, CMIN, CMAX));
    send_word(make_load(0, 32'sd0, 32'sd0));
    w = '1;
    w.func = FUNC_UNUSED;
    send_word(w);
    send_word(make_query(32'sd0, 32'sd0, 32'sd0, 32'sd0));
    set_count(10);
    send_word(make_remove(40));
    send_word(make_load(50, 32'sd0, 32'sd0));
    send_word(make_query(CMIN, CMAX, CMIN, CMAX));
    set_count(127);
    send_word(make_query(CMIN, CMAX, CMIN, CMAX));
  endtask

  task automatic test_random(int idle, int stall, int unsigned cnt, int n);
    in_word_t w;
    logic signed [31:0] a, b, c, d;
    int r;
    set_count(cnt);
    send_idle = idle;
    recv_stall = stall;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        a = pick_coord(); b = pick_coord(); c = pick_coord(); d = pick_coord();
        if ($urandom_range(0, 9) != 0) begin
          if (a > b) begin a = a ^ b; b = a ^ b; a = a ^ b; end
          if (c > d) begin c = c ^ d; d = c ^ d; c = c ^ d; end
        end
        w = make_query(a, b, c, d);
      end else if (r < 75) begin
        w = make_load($urandom_range(0, 63), pick_coord(), pick_coord());
      end else if (r < 95) begin
        w = make_remove($urandom_range(0, 63));
      end else begin
        w = make_query($urandom, $urandom, $urandom, $urandom);
        w.point_x = $urandom;
        w.point_y = $urandom;
        w.entry_index = 6'($urandom);
        w.func = FUNC_UNUSED;
      end
      if (w.func != FUNC_QUERY && $urandom_range(0, 9) == 0) begin
        w.box_min_x = $urandom; w.box_max_x = $urandom;
        w.box_min_y = $urandom; w.box_max_y = $urandom;
        if (w.func != FUNC_LOAD) begin w.point_x = $urandom; w.point_y = $urandom; end
      end
      send_word(w);
    end
    send_idle = 0;
    recv_stall = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill();
    test_directed();
    test_random(0, 0, 64, 37);
    test_random(53, 0, 127, 37);
    test_random(0, 53, $urandom_range(1, 63), 36);
    test_random(25, 25, 40, 36);
    drain();
    repeat (80) @(posedge clk);
    $display("sent %0d words over four idle phases and counts 0 to 127", words_sent);
    $display("checked %0d hit words; %0d mismatches", hits_seen, errors);
    if (errors == 0 && hit_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
